@@ hdl/spnh_pkg.sv @@
// Shared constants for the shortest-path next-hop router.
// Standalone package; used by shortest_path_next_hop_router.
`timescale 1ns / 1ps
`default_nettype none

package spnh_pkg;

    localparam int ADDR_W   = 3;
    localparam int WEIGHT_W = 8;
    localparam int PERIOD_W = 8;

    localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 8'd20;
    localparam logic [WEIGHT_W-1:0] BASE_WEIGHT    = 8'd1;
    localparam logic [WEIGHT_W-1:0] MAX_WEIGHT     = 8'd255;
    localparam logic [ADDR_W-1:0]   DEFAULT_OWN    = 3'd0;

    // Register index, taken from paddr[2]
    localparam logic REG_OWN_ADDRESS  = 1'b0;
    localparam logic REG_RESET_PERIOD = 1'b1;

    localparam logic OP_SEND    = 1'b0;
    localparam logic OP_FORWARD = 1'b1;

endpackage

`default_nettype wire

@@ hdl/shortest_path_next_hop_router.sv @@
// Shortest-path next-hop router: link weight store, Dijkstra sequencer, APB registers.
// Depends on spnh_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Each request beat (start while busy is low) names a destination; one cycle-wide
// done strobe later carries hop_node, and the result cannot be held off. Requests
// whose destination is this node or lies outside the graph, or whose own address
// lies outside it, answer in the cycle after acceptance. Routed requests load the
// first row, run up to NODES-2 further relax rounds, walk the predecessors back
// from the destination, and on a send raise the link weight in a read and a write
// state. The run length is set by the weight store's single read port, which
// delivers one link per cycle to the shared compare-and-add unit. busy stays high
// for the whole run.
module shortest_path_next_hop_router #(
    parameter int NODES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request / result
    input  wire logic        start,
    output logic             busy,
    input  wire logic        opcode,
    input  wire logic [2:0]  dest_node,
    output logic             done,
    output logic [2:0]       hop_node,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LINKS = NODES * (NODES - 1) / 2;
    localparam int NW    = $clog2(NODES);
    localparam int CW    = $clog2(NODES + 1);
    localparam int SW    = (LINKS > 1) ? $clog2(LINKS) : 1;
    localparam int MAXD  = (NODES - 1) * 255;
    localparam int DW    = $clog2(MAXD + 2);

    localparam logic [DW-1:0] DINF    = '1;
    localparam logic [CW-1:0] NODES_C = CW'(NODES);
    localparam logic [CW-1:0] ROUNDS  = CW'(NODES - 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_RELAX,
        S_WALK,
        S_INC_RD,
        S_INC_WR
    } state_t;

    function automatic logic [SW-1:0] pair_slot(input logic [NW-1:0] a,
                                                 input logic [NW-1:0] b);
        logic [15:0] l;
        logic [15:0] h;
        logic [15:0] s;
        l = (a < b) ? 16'(a) : 16'(b);
        h = (a < b) ? 16'(b) : 16'(a);
        s = l * 16'(NODES) - ((l * (l + 16'd1)) >> 1) + h - l - 16'd1;
        if (a == b) begin
            s = 16'd0;
        end
        return s[SW-1:0];
    endfunction

    function automatic logic [NW-1:0] to_node(input logic [2:0] a);
        logic [NW+2:0] e;
        e = {{NW{1'b0}}, a};
        return e[NW-1:0];
    endfunction

    function automatic logic [2:0] to_addr(input logic [NW-1:0] n);
        logic [NW+2:0] e;
        e = {3'b000, n};
        return e[2:0];
    endfunction

    // configuration and control
    state_t                       state_reg;
    logic [spnh_pkg::ADDR_W-1:0]  own_address_reg;
    logic [spnh_pkg::PERIOD_W-1:0] reset_period_reg;
    logic [spnh_pkg::PERIOD_W-1:0] send_counter_reg;
    logic [LINKS-1:0]             wvalid_reg;
    logic                         done_reg;
    logic [2:0]                   hop_node_reg;

    // search state
    logic [NW-1:0]     src_reg;
    logic [NW-1:0]     dst_reg;
    logic [NW-1:0]     anchor_reg;
    logic [DW-1:0]     best_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     rounds_reg;
    logic              cand_found_reg;
    logic [DW-1:0]     cand_dist_reg;
    logic [NW-1:0]     cand_idx_reg;
    logic [NODES-1:0]  seen_reg;
    logic [DW-1:0]     dist_reg [NODES];
    logic [NW-1:0]     pred_reg [NODES];
    logic [NW-1:0]     cur_reg;
    logic [CW-1:0]     steps_reg;
    logic              do_inc_reg;

    // weight store
    logic [spnh_pkg::WEIGHT_W-1:0] link_mem [LINKS];
    logic [spnh_pkg::WEIGHT_W-1:0] rdata_reg;
    logic                          rvalid_reg;

    logic [NW-1:0]  issue_idx;
    logic [NW-1:0]  proc_idx;
    logic [SW-1:0]  inc_slot;
    logic [SW-1:0]  raddr;
    logic [spnh_pkg::WEIGHT_W-1:0] w;
    logic           same;
    logic           edge_ok;
    logic [DW-1:0]  dist_p;
    logic [DW:0]    relax_sum;
    logic           relax_upd;
    logic [DW-1:0]  new_d;
    logic           cand_take;
    logic           fin_found;
    logic [DW-1:0]  fin_dist;
    logic [NW-1:0]  fin_idx;
    logic           phase_end;
    logic [NW-1:0]  pred_cur;
    logic           walk_stop;
    logic           mem_we;
    logic [spnh_pkg::WEIGHT_W-1:0] cnt_inc;
    logic           req_send;
    logic           req_valid;
    logic           cfg_write;

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign hop_node  = hop_node_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            spnh_pkg::REG_OWN_ADDRESS:  prdata = {29'd0, own_address_reg};
            spnh_pkg::REG_RESET_PERIOD: prdata = {24'd0, reset_period_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign issue_idx = cnt_reg[NW-1:0];
    assign proc_idx  = NW'(cnt_reg - CW'(1));
    assign inc_slot  = pair_slot(src_reg, dst_reg);
    assign raddr     = (state_reg == S_INC_RD) ? inc_slot : pair_slot(anchor_reg, issue_idx);

    // shared compare-and-add on the link just read
    assign w         = rvalid_reg ? rdata_reg : spnh_pkg::BASE_WEIGHT;
    assign same      = (anchor_reg == proc_idx);
    assign edge_ok   = !same && (w != '0);
    assign dist_p    = dist_reg[proc_idx];
    assign relax_sum = {1'b0, best_reg} + (DW+1)'(w);
    assign relax_upd = !seen_reg[proc_idx] && edge_ok && (relax_sum < {1'b0, dist_p});

    always_comb
    begin
        if (state_reg == S_INIT) begin
            new_d     = same ? '0 : (edge_ok ? DW'(w) : DINF);
            cand_take = !same && (new_d < cand_dist_reg);
        end else begin
            new_d     = relax_upd ? relax_sum[DW-1:0] : dist_p;
            cand_take = !seen_reg[proc_idx] && (new_d < cand_dist_reg);
        end
    end

    assign fin_found = cand_found_reg || cand_take;
    assign fin_dist  = cand_take ? new_d : cand_dist_reg;
    assign fin_idx   = cand_take ? proc_idx : cand_idx_reg;
    assign phase_end = (cnt_reg == NODES_C);

    assign pred_cur  = pred_reg[cur_reg];
    assign walk_stop = (steps_reg == NODES_C) || (pred_cur == src_reg);

    assign mem_we    = (state_reg == S_INC_WR) && (w != spnh_pkg::MAX_WEIGHT);
    assign cnt_inc   = send_counter_reg + 8'd1;
    assign req_send  = (opcode == spnh_pkg::OP_SEND);
    assign req_valid = ({2'b00, own_address_reg} < 5'(NODES))
                    && ({2'b00, dest_node} < 5'(NODES));

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            link_mem[inc_slot] <= w + 8'd1;
        end
        rdata_reg  <= link_mem[raddr];
        rvalid_reg <= wvalid_reg[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            own_address_reg  <= spnh_pkg::DEFAULT_OWN;
            reset_period_reg <= spnh_pkg::DEFAULT_PERIOD;
            send_counter_reg <= '0;
            wvalid_reg       <= '0;
            done_reg         <= 1'b0;
            hop_node_reg     <= '0;
            cnt_reg          <= '0;
            rounds_reg       <= '0;
            steps_reg        <= '0;
            cand_found_reg   <= 1'b0;
            do_inc_reg       <= 1'b0;
            seen_reg         <= '0;
        end else begin
            done_reg <= 1'b0;

            if (cfg_write) begin
                unique case (paddr[2])
                    spnh_pkg::REG_OWN_ADDRESS:  own_address_reg  <= pwdata[2:0];
                    spnh_pkg::REG_RESET_PERIOD: reset_period_reg <= pwdata[7:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start) begin
                        if (req_send) begin
                            if (cnt_inc >= reset_period_reg) begin
                                wvalid_reg       <= '0;
                                send_counter_reg <= '0;
                            end else begin
                                send_counter_reg <= cnt_inc;
                            end
                        end
                        priority if (!req_valid) begin
                            done_reg     <= 1'b1;
                            hop_node_reg <= dest_node;
                        end else if (own_address_reg == dest_node) begin
                            done_reg     <= 1'b1;
                            hop_node_reg <= own_address_reg;
                        end else begin
                            src_reg        <= to_node(own_address_reg);
                            dst_reg        <= to_node(dest_node);
                            anchor_reg     <= to_node(own_address_reg);
                            seen_reg       <= '0;
                            cnt_reg        <= '0;
                            rounds_reg     <= '0;
                            cand_found_reg <= 1'b0;
                            cand_dist_reg  <= DINF;
                            do_inc_reg     <= req_send;
                            state_reg      <= S_INIT;
                        end
                    end
                end

                S_INIT, S_RELAX:
                begin
                    if (cnt_reg != '0) begin
                        dist_reg[proc_idx] <= new_d;
                        if (state_reg == S_INIT) begin
                            pred_reg[proc_idx] <= src_reg;
                            if (same) begin
                                seen_reg[proc_idx] <= 1'b1;
                            end
                        end else if (relax_upd) begin
                            pred_reg[proc_idx] <= anchor_reg;
                        end
                        if (cand_take) begin
                            cand_found_reg <= 1'b1;
                            cand_dist_reg  <= new_d;
                            cand_idx_reg   <= proc_idx;
                        end
                    end
                    if (phase_end) begin
                        if (fin_found && (rounds_reg < ROUNDS)) begin
                            // close the nearest open node and relax from it
                            seen_reg[fin_idx] <= 1'b1;
                            anchor_reg        <= fin_idx;
                            best_reg          <= fin_dist;
                            rounds_reg        <= rounds_reg + CW'(1);
                            cnt_reg           <= '0;
                            cand_found_reg    <= 1'b0;
                            cand_dist_reg     <= DINF;
                            state_reg         <= S_RELAX;
                        end else begin
                            cur_reg   <= dst_reg;
                            steps_reg <= '0;
                            state_reg <= S_WALK;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end

                S_WALK:
                begin
                    if (walk_stop) begin
                        hop_node_reg <= to_addr(cur_reg);
                        if (do_inc_reg) begin
                            state_reg <= S_INC_RD;
                        end else begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end else begin
                        cur_reg   <= pred_cur;
                        steps_reg <= steps_reg + CW'(1);
                    end
                end

                S_INC_RD:
                begin
                    state_reg <= S_INC_WR;
                end

                S_INC_WR:
                begin
                    if (mem_we) begin
                        wvalid_reg[inc_slot] <= 1'b1;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
